// File: rtl/slo_pkg.sv
// shared types and constants for the set-associative lru order block
// no dependencies; imported by every module of the block
`default_nettype none

package slo_pkg;

   // fixed field widths of the request and response items
   localparam int CMD_W    = 1;
   localparam int SET_IN_W = 6;
   localparam int WAY_IN_W = 4;
   localparam int LRU_W    = 3;

   // default geometry
   localparam int DEF_SETS  = 64;
   localparam int DEF_ASSOC = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_TOUCH = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic {
      STATUS_OK      = 1'b0,
      STATUS_BAD_WAY = 1'b1
   } status_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   typedef struct packed {
      cmd_type               command;
      logic [SET_IN_W-1:0]   set_index;
      logic [WAY_IN_W-1:0]   way;
   } req_type;

   typedef struct packed {
      logic [LRU_W-1:0]      lru_way;
      status_type            status;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/slo_mem.sv
// single-port-write, single-port-read synchronous memory holding one recency list per set
// read data registered; uses slo_pkg
`default_nettype none

module slo_mem
   import slo_pkg::*;
#(
   parameter int DEPTH  = DEF_SETS,
   parameter int WIDTH  = DEF_ASSOC * $clog2(DEF_ASSOC),
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/slo_update.sv
// move-to-front update of one recency list and victim extraction
// purely combinational; uses slo_pkg
`default_nettype none

module slo_update
   import slo_pkg::*;
#(
   parameter int ASSOC = DEF_ASSOC,
   parameter int WAY_W = $clog2(DEF_ASSOC)
) (
   input  wire cmd_type                          command,
   input  wire logic [WAY_IN_W-1:0]              way,
   input  wire logic [ASSOC-1:0][WAY_W-1:0]      cur_list,
   output logic      [ASSOC-1:0][WAY_W-1:0]      new_list,
   output rsp_type                               rsp
);

   logic             touch_ok;
   logic [WAY_W-1:0] way_n;
   logic             seen;
   logic [ASSOC-1:0][WAY_W-1:0] moved;

   // range check of the touched way
   always_comb begin
      touch_ok = (command == CMD_TOUCH) &&
                 ({1'b0, way} < (WAY_IN_W + 1)'(ASSOC));
      way_n    = WAY_W'(way);
   end

   // entries ahead of the touched way shift down one place
   always_comb begin
      seen     = (cur_list[0] == way_n);
      moved[0] = way_n;
      for (int i = 1; i < ASSOC; i++) begin
         moved[i] = seen ? cur_list[i] : cur_list[i-1];
         seen     = seen | (cur_list[i] == way_n);
      end
   end

   // result item and written-back list
   always_comb begin
      new_list    = touch_ok ? moved : cur_list;
      rsp.lru_way = LRU_W'(new_list[ASSOC-1]);
      rsp.status  = ((command == CMD_TOUCH) && !touch_ok) ? STATUS_BAD_WAY : STATUS_OK;
   end

endmodule

`default_nettype wire

// File: rtl/set_assoc_lru_order.sv
// Keeps a true-LRU recency list of the ways of every set and answers each request
// item with the set's victim way. After reset a clearing pass loads every set with
// way ASSOC-1 most recent down to way 0 least recent; req_ready stays low during
// it. Then one item is taken per cycle while the response side does not stall: the
// set's list is read from the memory at the accept edge, then updated and written
// back when the response register is loaded, and the response is registered.
// The throughput is set by the read-modify-write loop on the set memory; a request
// accepted as its set is written back gets the new list by forwarding.
// top level; uses slo_pkg, slo_mem and slo_update
`default_nettype none

module set_assoc_lru_order
   import slo_pkg::*;
#(
   parameter int SETS  = DEF_SETS,
   parameter int ASSOC = DEF_ASSOC
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W  = $clog2(ASSOC);
   localparam int LIST_W = ASSOC * WAY_W;

   typedef logic [ASSOC-1:0][WAY_W-1:0] list_type;

   state_type state_ff, state_in;
   logic [SET_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic             clearing;
   logic             req_fire;
   logic             rsp_load;
   logic [SET_W-1:0] set_sel;
   logic [SET_IN_W-1:0] set_rem;

   logic              s2_valid_ff;
   cmd_type           s2_cmd_ff;
   logic [WAY_IN_W-1:0] s2_way_ff;
   logic [SET_W-1:0]  s2_set_ff;
   logic              fwd_hit_ff;
   list_type          fwd_list_ff;

   list_type          rd_list;
   list_type          cur_list;
   list_type          new_list;
   list_type          clr_list;
   rsp_type           upd_rsp;

   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic              wr_en;
   logic [SET_W-1:0]  wr_addr;
   list_type          wr_data;

   // set index wraps modulo SETS by conditional subtraction of scaled multiples
   always_comb begin
      set_rem = req_data.set_index;
      for (int k = SET_IN_W - 1; k >= 0; k--) begin
         if (int'(set_rem) >= (SETS << k)) begin
            set_rem = set_rem - SET_IN_W'(SETS << k);
         end
      end
      set_sel = SET_W'(set_rem);
   end

   // reset list: way ASSOC-1 first down to way 0 last
   always_comb begin
      for (int i = 0; i < ASSOC; i++) begin
         clr_list[i] = WAY_W'(ASSOC - 1 - i);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == SET_W'(SETS - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: state_in = ST_RUN;
         default: state_in = ST_CLEAR;
      endcase
   end

   // state outputs and handshake
   always_comb begin
      clearing   = (state_ff == ST_CLEAR);
      clr_cnt_in = clearing ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      rsp_load   = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready  = !clearing && (!s2_valid_ff || rsp_load);
      req_fire   = req_valid && req_ready;
   end

   // memory write port: clearing pass or write-back of the updated list
   always_comb begin
      if (clearing) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = clr_list;
      end else begin
         wr_en   = rsp_load;
         wr_addr = s2_set_ff;
         wr_data = new_list;
      end
   end

   slo_mem #(
      .DEPTH  (SETS),
      .WIDTH  (LIST_W),
      .ADDR_W (SET_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (set_sel),
      .rd_data (rd_list),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // forwarded list when the previous item wrote the same set
   assign cur_list = fwd_hit_ff ? fwd_list_ff : rd_list;

   slo_update #(
      .ASSOC (ASSOC),
      .WAY_W (WAY_W)
   ) u_update (
      .command  (s2_cmd_ff),
      .way      (s2_way_ff),
      .cur_list (cur_list),
      .new_list (new_list),
      .rsp      (upd_rsp)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         if (req_fire) begin
            s2_valid_ff <= 1'b1;
         end else if (rsp_load) begin
            s2_valid_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // update stage payload and forwarding capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s2_cmd_ff   <= req_data.command;
         s2_way_ff   <= req_data.way;
         s2_set_ff   <= set_sel;
         fwd_hit_ff  <= rsp_load && (set_sel == s2_set_ff);
         fwd_list_ff <= new_list;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
